### hw/rtl/lsg_pkg.sv
// Shared constants for the Lab to sRGB gamut check pipeline.
// Holds field widths, fixed-point constants and the conversion matrix.
// Used by lsg_decomp, lab_srgb_gamut_check and lsg_chk.
package lsg_pkg;

  localparam int L_W = 15;
  localparam int AB_W = 16;

  // Working value formats (signed, 16 fraction bits).
  localparam int FW = 18;
  localparam int DW = 20;
  localparam int SQW = 19;
  localparam int XW = 20;
  localparam int PW = 36;
  localparam int SW = 38;

  localparam int QS = 16;
  localparam int RND = 32768;

  // Numerator widths of the three front-end divisions.
  localparam int FY_NW = 25;
  localparam int AB_NW = 24;
  localparam int FY_OFFS = 4096;
  localparam int FY_DIV = 116;
  localparam int FX_DIV = 500;
  localparam int FZ_DIV = 200;

  // Inverse companding.
  localparam int KNEE = 580;
  localparam int OFFS = 9039;
  localparam int LIN_SCALE = 1000;
  localparam int LIN_DIV = 7787;
  localparam int LIN_NW = 29;

  localparam int WHITE_X = 62290;
  localparam int WHITE_Z = 71358;

  // XYZ to linear sRGB, scaled by 10000.
  localparam int M_RX = 32406;
  localparam int M_RY = -15372;
  localparam int M_RZ = -4986;
  localparam int M_GX = -9689;
  localparam int M_GY = 18758;
  localparam int M_GZ = 415;
  localparam int M_BX = 557;
  localparam int M_BY = -2040;
  localparam int M_BZ = 10570;

  // A channel sum s rounds into [0, 65536] exactly when S_LO <= s <= S_HI.
  localparam int S_LO = -5000;
  localparam int S_HI = 655364999;

  // Register stages from the accepting edge to the result register.
  localparam int PIPE_DEPTH = 15;

endpackage

### hw/rtl/lsg_cdiv.sv
// Pipelined signed division by a constant, rounding to nearest with ties up.
// Reciprocal multiply, remainder check and a one-step correction, three stages.
// Stands alone; instantiated by lsg_decomp and lab_srgb_gamut_check.
module lsg_cdiv #(
  parameter int NW = 24,
  parameter int QW = 18,
  parameter int DIV = 116
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] num,
  output logic signed [QW-1:0] quo
);

  localparam int S = NW;
  localparam longint MUL = ((longint'(1) <<< S) + longint'(DIV) - 1) / DIV;
  localparam int MW = $clog2(MUL) + 2;
  localparam int HALF = DIV / 2;
  localparam int PRW = NW + 1 + MW;
  localparam int RW = NW + 2;

  logic signed [NW:0]    m_nxt, m_r;
  logic signed [PRW-1:0] p_nxt, p_r;
  logic signed [QW:0]    q0_nxt, q0_r;
  logic signed [RW-1:0]  r0_nxt, r0_r;
  logic signed [QW:0]    q_nxt;
  logic signed [QW-1:0]  quo_r;

  always_comb begin
    m_nxt = (NW+1)'(num) + (NW+1)'(HALF);
    p_nxt = PRW'(m_nxt) * PRW'(MUL);
    q0_nxt = (QW+1)'(p_r >>> S);
    r0_nxt = RW'(m_r) - RW'(q0_nxt) * RW'(DIV);
  end

  always_comb begin
    priority if (r0_r < RW'(0)) begin
      q_nxt = q0_r - (QW+1)'(1);
    end else if (r0_r >= RW'(DIV)) begin
      q_nxt = q0_r + (QW+1)'(1);
    end else begin
      q_nxt = q0_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    p_r <= p_nxt;
    q0_r <= q0_nxt;
    r0_r <= r0_nxt;
    quo_r <= QW'(q_nxt);
  end

  assign quo = quo_r;

endmodule

### hw/rtl/lsg_decomp.sv
// Inverse Lab companding for one channel: cube above the knee, linear below.
// Five register stages from f to the selected value.
// Depends on lsg_pkg and lsg_cdiv.
module lsg_decomp (
  input  logic                          clk,
  input  logic signed [lsg_pkg::FW-1:0] f,
  output logic signed [lsg_pkg::DW-1:0] d
);

  localparam int FW = lsg_pkg::FW;
  localparam int DW = lsg_pkg::DW;
  localparam int SQW = lsg_pkg::SQW;
  localparam int LNW = lsg_pkg::LIN_NW;
  localparam int CPW = SQW + FW;

  logic signed [2*FW-1:0] sqp_nxt, sqp_r;
  logic signed [FW-1:0]   f1_r, f2_r;
  logic signed [SQW-1:0]  sq_nxt, sq_r;
  logic signed [CPW-1:0]  cp_nxt, cp_r;
  logic signed [DW-1:0]   c_nxt, c_r;
  logic signed [LNW-1:0]  ln_nxt, ln_r;
  logic signed [DW-1:0]   lin;
  logic signed [DW-1:0]   d_nxt, d_r;

  always_comb begin
    sqp_nxt = (2*FW)'(f) * (2*FW)'(f);
    sq_nxt = SQW'((sqp_r + (2*FW)'(lsg_pkg::RND)) >>> lsg_pkg::QS);
    cp_nxt = CPW'(sq_r) * CPW'(f2_r);
    c_nxt = DW'((cp_r + CPW'(lsg_pkg::RND)) >>> lsg_pkg::QS);
    ln_nxt = (LNW'(f) - LNW'(lsg_pkg::OFFS)) * LNW'(lsg_pkg::LIN_SCALE);
    d_nxt = (c_r > DW'(lsg_pkg::KNEE)) ? c_r : lin;
  end

  lsg_cdiv #(
    .NW (LNW),
    .QW (DW),
    .DIV(lsg_pkg::LIN_DIV)
  ) u_lin_div (
    .clk(clk),
    .num(ln_r),
    .quo(lin)
  );

  always_ff @(posedge clk) begin
    sqp_r <= sqp_nxt;
    f1_r <= f;
    ln_r <= ln_nxt;
    sq_r <= sq_nxt;
    f2_r <= f1_r;
    cp_r <= cp_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

  assign d = d_r;

endmodule

### hw/rtl/lab_srgb_gamut_check.sv
// Top level of the Lab to sRGB gamut check.
// Depends on lsg_pkg, lsg_cdiv and lsg_decomp.
//
// A beat is taken on each rising edge where start is high and busy is low.
// busy is low whenever reset is released, so a new Lab color can be taken
// in every cycle; the block sustains one color per clock.
// Each taken beat gives exactly one result: out_valid is high for one cycle,
// when the beat reaches the result register, with out_in_gamut set when all three
// linear sRGB channels lie in [0, 1]. Results leave in the order taken.
// The 15 register stages cover three constant divisions, the cube and
// linear inverse companding, the white point scaling, the matrix products,
// the channel sums and the range compare.
// The receiver cannot stall, so the pipeline never holds.
// Synchronous reset clears every valid bit, so no result is issued for
// beats in flight; busy is high while reset is asserted.
module lab_srgb_gamut_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic        [lsg_pkg::L_W-1:0]    in_l_star,
  input  logic signed [lsg_pkg::AB_W-1:0]   in_a_star,
  input  logic signed [lsg_pkg::AB_W-1:0]   in_b_star,
  output logic                              out_valid,
  output logic                              out_in_gamut
);

  localparam int FW = lsg_pkg::FW;
  localparam int DW = lsg_pkg::DW;
  localparam int XW = lsg_pkg::XW;
  localparam int PW = lsg_pkg::PW;
  localparam int SW = lsg_pkg::SW;
  localparam int SCW = DW + 18;
  localparam int DEPTH = lsg_pkg::PIPE_DEPTH;

  logic                           accept;
  logic [DEPTH-1:0]               v_nxt, v_r;

  logic [lsg_pkg::L_W-1:0]        l_r;
  logic signed [lsg_pkg::AB_W-1:0] a_r, b_r;

  logic signed [lsg_pkg::FY_NW-1:0] fy_num;
  logic signed [lsg_pkg::AB_NW-1:0] da_num, db_num;
  logic signed [FW-1:0]           fy_q, da_q, db_q;
  logic signed [FW-1:0]           fx_nxt, fz_nxt;
  logic signed [FW-1:0]           fx_r, fy_r, fz_r;

  logic signed [DW-1:0]           dx, dy, dz;
  logic signed [SCW-1:0]          xp_nxt, zp_nxt, xp_r, zp_r;
  logic signed [DW-1:0]           y1_r;
  logic signed [XW-1:0]           x_nxt, z_nxt, x_r, y_r, z_r;

  logic signed [PW-1:0]           mr_r [3];
  logic signed [PW-1:0]           mg_r [3];
  logic signed [PW-1:0]           mb_r [3];
  logic signed [SW-1:0]           sr_nxt, sg_nxt, sb_nxt;
  logic signed [SW-1:0]           sr_r, sg_r, sb_r;
  logic                           gam_nxt, gam_r;

  assign busy = !rst_n;
  assign accept = start && !busy;

  always_comb begin
    v_nxt = {v_r[DEPTH-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      l_r <= in_l_star;
      a_r <= in_a_star;
      b_r <= in_b_star;
    end
  end

  always_comb begin
    fy_num = $signed({1'b0, 16'(l_r) + 16'(lsg_pkg::FY_OFFS), 8'h00});
    da_num = $signed({a_r, 8'h00});
    db_num = $signed({b_r, 8'h00});
  end

  lsg_cdiv #(
    .NW (lsg_pkg::FY_NW),
    .QW (FW),
    .DIV(lsg_pkg::FY_DIV)
  ) u_fy_div (
    .clk(clk),
    .num(fy_num),
    .quo(fy_q)
  );

  lsg_cdiv #(
    .NW (lsg_pkg::AB_NW),
    .QW (FW),
    .DIV(lsg_pkg::FX_DIV)
  ) u_fx_div (
    .clk(clk),
    .num(da_num),
    .quo(da_q)
  );

  lsg_cdiv #(
    .NW (lsg_pkg::AB_NW),
    .QW (FW),
    .DIV(lsg_pkg::FZ_DIV)
  ) u_fz_div (
    .clk(clk),
    .num(db_num),
    .quo(db_q)
  );

  always_comb begin
    fx_nxt = fy_q + da_q;
    fz_nxt = fy_q - db_q;
  end

  always_ff @(posedge clk) begin
    fx_r <= fx_nxt;
    fy_r <= fy_q;
    fz_r <= fz_nxt;
  end

  lsg_decomp u_decomp_x (
    .clk(clk),
    .f  (fx_r),
    .d  (dx)
  );

  lsg_decomp u_decomp_y (
    .clk(clk),
    .f  (fy_r),
    .d  (dy)
  );

  lsg_decomp u_decomp_z (
    .clk(clk),
    .f  (fz_r),
    .d  (dz)
  );

  always_comb begin
    xp_nxt = SCW'(dx) * SCW'(lsg_pkg::WHITE_X);
    zp_nxt = SCW'(dz) * SCW'(lsg_pkg::WHITE_Z);
    x_nxt = XW'((xp_r + SCW'(lsg_pkg::RND)) >>> lsg_pkg::QS);
    z_nxt = XW'((zp_r + SCW'(lsg_pkg::RND)) >>> lsg_pkg::QS);
  end

  always_ff @(posedge clk) begin
    xp_r <= xp_nxt;
    zp_r <= zp_nxt;
    y1_r <= dy;
    x_r <= x_nxt;
    y_r <= XW'(y1_r);
    z_r <= z_nxt;
  end

  always_ff @(posedge clk) begin
    mr_r[0] <= PW'(x_r) * PW'(lsg_pkg::M_RX);
    mr_r[1] <= PW'(y_r) * PW'(lsg_pkg::M_RY);
    mr_r[2] <= PW'(z_r) * PW'(lsg_pkg::M_RZ);
    mg_r[0] <= PW'(x_r) * PW'(lsg_pkg::M_GX);
    mg_r[1] <= PW'(y_r) * PW'(lsg_pkg::M_GY);
    mg_r[2] <= PW'(z_r) * PW'(lsg_pkg::M_GZ);
    mb_r[0] <= PW'(x_r) * PW'(lsg_pkg::M_BX);
    mb_r[1] <= PW'(y_r) * PW'(lsg_pkg::M_BY);
    mb_r[2] <= PW'(z_r) * PW'(lsg_pkg::M_BZ);
  end

  always_comb begin
    sr_nxt = SW'(mr_r[0]) + SW'(mr_r[1]) + SW'(mr_r[2]);
    sg_nxt = SW'(mg_r[0]) + SW'(mg_r[1]) + SW'(mg_r[2]);
    sb_nxt = SW'(mb_r[0]) + SW'(mb_r[1]) + SW'(mb_r[2]);
    gam_nxt = (sr_r >= SW'(lsg_pkg::S_LO)) && (sr_r <= SW'(lsg_pkg::S_HI))
           && (sg_r >= SW'(lsg_pkg::S_LO)) && (sg_r <= SW'(lsg_pkg::S_HI))
           && (sb_r >= SW'(lsg_pkg::S_LO)) && (sb_r <= SW'(lsg_pkg::S_HI));
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    sg_r <= sg_nxt;
    sb_r <= sb_nxt;
    gam_r <= gam_nxt;
  end

  assign out_valid = v_r[DEPTH-1];
  assign out_in_gamut = gam_r;

endmodule

### hw/rtl/lsg_chk.sv
// Port-level checker for lab_srgb_gamut_check, attached by bind.
// Depends on lsg_pkg for the pipeline depth.
module lsg_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  localparam int DEPTH = lsg_pkg::PIPE_DEPTH;

  // Every beat taken produces its result at the end of the pipeline.
  a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##DEPTH out_valid)
    else $error("taken beat produced no result");

  // No result appears without a matching beat taken earlier.
  a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, DEPTH))
    else $error("result without a matching beat");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result issued right after reset");

  // The block can take a beat in every cycle outside reset.
  a_never_busy: assert property (@(posedge clk)
    rst_n |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind lab_srgb_gamut_check lsg_chk u_lsg_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid)
);

### test/tb.sv
`timescale 1ns / 100ps
// Testbench for lab_srgb_gamut_check: drives directed Lab colors, then random
// bursts; compares each in_gamut strobe with an in-house fixed-point prediction.
// Depends on lsg_pkg and the lab_srgb_gamut_check RTL.

class gamut_scoreboard;
  bit gamut_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Round to nearest, ties toward plus infinity; d is always positive.
  function longint round_div(longint n, longint d);
    longint m;
    m = n + d / 2;
    if (m >= 0) begin
      return m / d;
    end
    return -((-m + d - 1) / d);
  endfunction

  function longint q16_mul(longint x, longint y);
    return round_div(x * y, 65536);
  endfunction

  function longint lab_inverse(longint f);
    longint c;
    c = q16_mul(q16_mul(f, f), f);
    if (c > lsg_pkg::KNEE) begin
      return c;
    end
    return round_div((f - lsg_pkg::OFFS) * lsg_pkg::LIN_SCALE, lsg_pkg::LIN_DIV);
  endfunction

  function bit unit_channel(longint v);
    return (v >= 0) && (v <= 65536);
  endfunction

  function bit predict_in_gamut(logic [lsg_pkg::L_W-1:0] l,
                                logic signed [lsg_pkg::AB_W-1:0] a,
                                logic signed [lsg_pkg::AB_W-1:0] b);
    longint fy, fx, fz, x, y, z, r, g, bl;
    fy = round_div((longint'(l) + 16 * 256) * 256, 116);
    fx = fy + round_div(longint'(a) * 256, 500);
    fz = fy - round_div(longint'(b) * 256, 200);
    x = q16_mul(lab_inverse(fx), lsg_pkg::WHITE_X);
    y = lab_inverse(fy);
    z = q16_mul(lab_inverse(fz), lsg_pkg::WHITE_Z);
    r = round_div(32406 * x - 15372 * y - 4986 * z, 10000);
    g = round_div(-9689 * x + 18758 * y + 415 * z, 10000);
    bl = round_div(557 * x - 2040 * y + 10570 * z, 10000);
    return unit_channel(r) && unit_channel(g) && unit_channel(bl);
  endfunction

  function void note_lab(logic [lsg_pkg::L_W-1:0] l,
                         logic signed [lsg_pkg::AB_W-1:0] a,
                         logic signed [lsg_pkg::AB_W-1:0] b);
    gamut_q.push_back(predict_in_gamut(l, a, b));
  endfunction

  function void check_result(logic got);
    bit want;
    if (gamut_q.size() == 0) begin
      $error("in_gamut: result with no color pending, actual %b", got);
      errors++;
      return;
    end
    want = gamut_q.pop_front();
    if (got !== want) begin
      $error("in_gamut: expected %0b, actual %b", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return gamut_q.size();
  endfunction
endclass

module tb;
  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic        [lsg_pkg::L_W-1:0]       in_l_star;
  logic signed [lsg_pkg::AB_W-1:0]      in_a_star;
  logic signed [lsg_pkg::AB_W-1:0]      in_b_star;
  logic                                 out_valid;
  logic                                 out_in_gamut;

  gamut_scoreboard sb;

  lab_srgb_gamut_check dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_l_star    (in_l_star),
    .in_a_star    (in_a_star),
    .in_b_star    (in_b_star),
    .out_valid    (out_valid),
    .out_in_gamut (out_in_gamut)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && start && busy === 1'b0) begin
      sb.note_lab(in_l_star, in_a_star, in_b_star);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      sb.check_result(out_in_gamut);
    end
  end

  // One beat: present the color, then hold it until an edge with busy low.
  task automatic send_lab(int l, int a, int b);
    @(negedge clk);
    start <= 1'b1;
    in_l_star <= l[lsg_pkg::L_W-1:0];
    in_a_star <= a[lsg_pkg::AB_W-1:0];
    in_b_star <= b[lsg_pkg::AB_W-1:0];
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_l_star <= lsg_pkg::L_W'($urandom);
      in_a_star <= lsg_pkg::AB_W'($urandom);
      in_b_star <= lsg_pkg::AB_W'($urandom);
    end
  endtask

  task automatic send_random_lab();
    int l, a, b, span;
    case ($urandom_range(0, 9))
      0: span = 32767;
      1, 2, 3: span = 10240;
      default: span = 2560;
    endcase
    if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 32767);
    else l = $urandom_range(0, 25600);
    if ($urandom_range(0, 9) == 0) begin
      a = $urandom_range(0, 65535) - 32768;
      b = $urandom_range(0, 65535) - 32768;
    end else begin
      a = $urandom_range(0, 2 * span) - span;
      b = $urandom_range(0, 2 * span) - span;
      if (a > 32767) a = 32767;
      if (b > 32767) b = 32767;
    end
    send_lab(l, a, b);
  endtask

  initial begin
    int sent, burst;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_l_star = '0;
    in_a_star = '0;
    in_b_star = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    idle_cycles(2);

    // Black, white, mid gray and lightness past 100.
    send_lab(0, 0, 0);
    send_lab(25600, 0, 0);
    send_lab(12800, 0, 0);
    send_lab(32767, 0, 0);
    // Extremes of a and b.
    send_lab(32767, 32767, 32767);
    send_lab(0, -32768, -32768);
    send_lab(0, 32767, -32768);
    send_lab(25600, -32768, 32767);
    send_lab(12800, 32767, 0);
    send_lab(12800, -32768, 0);
    send_lab(12800, 0, 32767);
    send_lab(12800, 0, -32768);
    send_lab(1, -1, -1);
    // Lightness around the cube knee.
    send_lab(2047, 0, 0);
    send_lab(2048, 0, 0);
    send_lab(2049, 0, 0);
    // The knee reached through a and through b.
    send_lab(0, 8828, 0);
    send_lab(0, 8829, 0);
    send_lab(0, 8830, 0);
    send_lab(0, 0, -3530);
    send_lab(0, 0, -3531);
    send_lab(0, 0, -3532);
    // Near the sRGB red primary.
    send_lab(13629, 20503, 17203);
    idle_cycles(3);

    sent = 0;
    while (sent < 1150) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random_lab();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    idle_cycles(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (lsg_pkg::PIPE_DEPTH + 5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
